// ===== rtl/cartridge_bank_mapper_top_assert.svh =====
// Assertion macros shared by the bank mapper RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef CARTRIDGE_BANK_MAPPER_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbm assertion failed");
`define CBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbm assertion failed");
`else
`define CBM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/cbm_pkg.sv =====
// Shared types and constants of the cartridge bank mapper.
// No dependencies.
package cbm_pkg;

    localparam int unsigned ADDR_W = 16;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned PHYS_W = 22;

    localparam logic [1:0] MAPPER_NONE  = 2'd0;
    localparam logic [1:0] MAPPER_TYPE1 = 2'd1;
    localparam logic [1:0] MAPPER_TYPE2 = 2'd2;

    // Control write windows, selected by address[14:13] below 0x8000
    localparam logic [1:0] WIN_RAM_EN   = 2'd0;
    localparam logic [1:0] WIN_ROM_LO   = 2'd1;
    localparam logic [1:0] WIN_ROM_HI   = 2'd2;
    localparam logic [1:0] WIN_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_CODE  = 4'hA;
    localparam logic [3:0] RAM_DIS_CODE = 4'h0;

    localparam logic [15:0] RO_AREA_LO  = 16'hFEA0;
    localparam logic [15:0] RO_AREA_HI  = 16'hFEFF;

    typedef enum logic [1:0] {
        TGT_INTERNAL = 2'd0,
        TGT_ROM      = 2'd1,
        TGT_RAM      = 2'd2,
        TGT_ABSORB   = 2'd3
    } target_t;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } access_t;

    typedef struct packed {
        logic [7:0] rom_bank;
        logic [1:0] ram_bank;
        logic       ram_enable;
        logic       rom_mode;
    } bank_state_t;

    typedef struct packed {
        target_t           target;
        logic [PHYS_W-1:0] physical_address;
        logic              write_strobe;
        logic [7:0]        rom_bank_now;
        logic [1:0]        ram_bank_now;
        logic              ram_enabled_now;
    } result_t;

endpackage

// ===== rtl/cbm_in_stage.sv =====
// Input register of the bank mapper: holds one bus request.
// Depends on cbm_pkg.
module cbm_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [15:0]            address,
    input  logic [7:0]             write_data,
    input  logic                   advance,
    output logic                   acc_valid,
    output cbm_pkg::access_t       acc
);
    import cbm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    access_t acc_reg;

    // Slot frees up when its request moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            acc_reg <= '{action: action, address: address, write_data: write_data};
        end
    end

    assign acc_valid = valid_reg;
    assign acc       = acc_reg;

endmodule

// ===== rtl/cbm_bank_ctrl.sv =====
// Mapper type and bank registers, with the control write decode.
// Depends on cbm_pkg.
module cbm_bank_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_data,
    input  logic                  advance,
    input  cbm_pkg::access_t      acc,
    output cbm_pkg::bank_state_t  state_next
);
    import cbm_pkg::*;

    logic [1:0]  mapper_type_reg;
    bank_state_t state_reg;
    logic        t1;
    logic        t2;

    assign t1 = (mapper_type_reg == MAPPER_TYPE1);
    assign t2 = (mapper_type_reg == MAPPER_TYPE2);

    always_comb
    begin
        state_next = state_reg;
        if (acc.action && !acc.address[15])
        begin
            unique case (acc.address[14:13])
                WIN_RAM_EN:
                begin
                    if (t1 || (t2 && !acc.address[4]))
                    begin
                        if (acc.write_data[3:0] == RAM_EN_CODE)
                        begin
                            state_next.ram_enable = 1'b1;
                        end
                        else if (acc.write_data[3:0] == RAM_DIS_CODE)
                        begin
                            state_next.ram_enable = 1'b0;
                        end
                    end
                end
                WIN_ROM_LO:
                begin
                    if (t2)
                    begin
                        state_next.rom_bank = {4'h0, acc.write_data[3:0]};
                    end
                    else if (t1)
                    begin
                        state_next.rom_bank = {state_reg.rom_bank[7:5], acc.write_data[4:0]};
                    end
                end
                WIN_ROM_HI:
                begin
                    if (t1)
                    begin
                        if (state_reg.rom_mode)
                        begin
                            state_next.rom_bank = {acc.write_data[7:5],
                                                   state_reg.rom_bank[4:0]};
                        end
                        else
                        begin
                            state_next.ram_bank = acc.write_data[1:0];
                        end
                    end
                end
                WIN_MODE:
                begin
                    if (t1)
                    begin
                        state_next.rom_mode = !acc.write_data[0];
                        if (!acc.write_data[0])
                        begin
                            state_next.ram_bank = 2'd0;
                        end
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        // Bank zero is never selected
        if (state_next.rom_bank == 8'd0)
        begin
            state_next.rom_bank = 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_type_reg <= MAPPER_NONE;
            state_reg       <= '{rom_bank: 8'd1, ram_bank: 2'd0,
                                 ram_enable: 1'b0, rom_mode: 1'b0};
        end
        else
        begin
            if (cfg_valid)
            begin
                mapper_type_reg <= cfg_data;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

endmodule

// ===== rtl/cbm_route.sv =====
// Classifies one bus request into a target and a physical address.
// Depends on cbm_pkg.
module cbm_route (
    input  cbm_pkg::access_t      acc,
    input  cbm_pkg::bank_state_t  state_next,
    output cbm_pkg::result_t      res
);
    import cbm_pkg::*;

    logic              in_ram_area;
    logic              in_rom_area;
    logic              in_ro_area;
    logic [PHYS_W-1:0] rom_phys;
    logic [PHYS_W-1:0] ram_phys;

    assign in_ram_area = (acc.address[15:13] == 3'b101);
    assign in_rom_area = (acc.address[15:14] == 2'b01);
    assign in_ro_area  = (acc.address >= RO_AREA_LO) && (acc.address < RO_AREA_HI);

    // Offset plus bank times window size is a plain concatenation
    assign rom_phys = {state_next.rom_bank, acc.address[13:0]};
    assign ram_phys = {7'd0, state_next.ram_bank, acc.address[12:0]};

    always_comb
    begin
        res.target           = TGT_INTERNAL;
        res.physical_address = {6'd0, acc.address};
        res.write_strobe     = 1'b0;
        res.rom_bank_now     = state_next.rom_bank;
        res.ram_bank_now     = state_next.ram_bank;
        res.ram_enabled_now  = state_next.ram_enable;
        if (acc.action)
        begin
            if (!acc.address[15])
            begin
                res.target           = TGT_ABSORB;
                res.physical_address = '0;
            end
            else if (in_ram_area)
            begin
                if (state_next.ram_enable)
                begin
                    res.target           = TGT_RAM;
                    res.physical_address = ram_phys;
                    res.write_strobe     = 1'b1;
                end
                else
                begin
                    res.target           = TGT_ABSORB;
                    res.physical_address = '0;
                end
            end
            else if (in_ro_area)
            begin
                res.target           = TGT_ABSORB;
                res.physical_address = '0;
            end
            else
            begin
                res.write_strobe = 1'b1;
            end
        end
        else if (in_rom_area)
        begin
            res.target           = TGT_ROM;
            res.physical_address = rom_phys;
        end
        else if (in_ram_area)
        begin
            res.target           = TGT_RAM;
            res.physical_address = ram_phys;
        end
    end

endmodule

// ===== rtl/cartridge_bank_mapper_top.sv =====
// Top level of the cartridge bank mapper: input stage, bank registers,
// routing logic and result register. Depends on cbm_pkg and the assert header.
//
// Usage:
//  - Request channel (in_valid/in_ready): one bus access per request, with
//    action (0 read, 1 write), address and write_data.
//  - Result channel (out_valid/out_ready): one result per request, in order:
//    target, physical_address, write_strobe and the bank state after it.
//  - Config channel (cfg_valid/cfg_ready, cfg_data): sets mapper_type; always
//    ready, to be written only while no request is in flight.
//  - Path: an accepted request passes the input register, then the result
//    register, before out_valid rises; a held result delays it. Throughput:
//    one request per cycle while out_ready stays high, set by the combinational
//    bank update between the two registers.
//  - Reset: both stages empty, mapper type none, ROM bank 1, RAM bank 0,
//    RAM disabled, RAM banking mode.
//  - Stall: a held result keeps its register; the input register still takes
//    one more request, then in_ready drops until out_ready returns.
//    Bank state changes only when a request moves into the result register.
`include "cartridge_bank_mapper_top_assert.svh"

module cartridge_bank_mapper_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  target,
    output logic [21:0] physical_address,
    output logic        write_strobe,
    output logic [7:0]  rom_bank_now,
    output logic [1:0]  ram_bank_now,
    output logic        ram_enabled_now
);
    import cbm_pkg::*;

    logic        acc_valid;
    access_t     acc;
    bank_state_t state_next;
    result_t     res;
    result_t     res_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;

    // A request moves on when the result register is empty or being drained
    assign advance   = acc_valid && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;

    cbm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .address    (address),
        .write_data (write_data),
        .advance    (advance),
        .acc_valid  (acc_valid),
        .acc        (acc)
    );

    cbm_bank_ctrl u_bank_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .advance    (advance),
        .acc        (acc),
        .state_next (state_next)
    );

    cbm_route u_route (
        .acc        (acc),
        .state_next (state_next),
        .res        (res)
    );

    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign target           = res_reg.target;
    assign physical_address = res_reg.physical_address;
    assign write_strobe     = res_reg.write_strobe;
    assign rom_bank_now     = res_reg.rom_bank_now;
    assign ram_bank_now     = res_reg.ram_bank_now;
    assign ram_enabled_now  = res_reg.ram_enabled_now;

    `CBM_ASSERT_SAME(a_rom_bank_nonzero, clk, rst_n,
                     out_valid_reg, res_reg.rom_bank_now != 8'd0)
    `CBM_ASSERT_SAME(a_strobe_not_absorbed, clk, rst_n,
                     out_valid_reg && res_reg.write_strobe, res_reg.target != TGT_ABSORB)
    `CBM_ASSERT_SAME(a_absorbed_zero_addr, clk, rst_n,
                     out_valid_reg && (res_reg.target == TGT_ABSORB),
                     res_reg.physical_address == '0)
    `CBM_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, out_valid_reg)

endmodule

// ===== tb/cbm_tb_pkg.sv =====
// Bench-wide codes for the cartridge bank mapper testbench.
// Shared by the checker and the stimulus top; no dependencies.
package cbm_tb_pkg;

    localparam logic       ACT_READ    = 1'b0;
    localparam logic       ACT_WRITE   = 1'b1;

endpackage

// ===== tb/cbm_checker.sv =====
// Bank mapper checker: watches config, request and result channels, keeps its
// own copy of the bank registers and compares every result in order.
// Depends on cbm_pkg and cbm_tb_pkg.
module cbm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  target,
    input  logic [21:0] physical_address,
    input  logic        write_strobe,
    input  logic [7:0]  rom_bank_now,
    input  logic [1:0]  ram_bank_now,
    input  logic        ram_enabled_now,
    output int          failures,
    output int          pending,
    output int          checked
);
    import cbm_pkg::*;
    import cbm_tb_pkg::*;

    logic [1:0] map_type;
    logic [7:0] rom_bank;
    logic [1:0] ram_bank;
    logic       ram_en;
    logic       rom_mode;
    result_t    routing_q[$];

    function automatic logic [7:0] nonzero_bank(input logic [7:0] bank);
        return (bank == 8'd0) ? 8'd1 : bank;
    endfunction

    // register writes below 0x8000
    task automatic apply_control_write(input logic [15:0] addr, input logic [7:0] data);
        logic t1;
        logic t2;
        t1 = (map_type == MAPPER_TYPE1);
        t2 = (map_type == MAPPER_TYPE2);
        case (addr[14:13])
            WIN_RAM_EN:
            begin
                if ((t1 || t2) && !(t2 && addr[4]))
                begin
                    if (data[3:0] == RAM_EN_CODE)
                        ram_en = 1'b1;
                    else if (data[3:0] == RAM_DIS_CODE)
                        ram_en = 1'b0;
                end
            end
            WIN_ROM_LO:
            begin
                if (t2)
                    rom_bank = nonzero_bank({4'd0, data[3:0]});
                else if (t1)
                    rom_bank = nonzero_bank({rom_bank[7:5], data[4:0]});
            end
            WIN_ROM_HI:
            begin
                if (t1)
                begin
                    if (rom_mode)
                        rom_bank = nonzero_bank({data[7:5], rom_bank[4:0]});
                    else
                        ram_bank = data[1:0];
                end
            end
            default:
            begin
                if (t1)
                begin
                    rom_mode = ~data[0];
                    if (rom_mode)
                        ram_bank = 2'd0;
                end
            end
        endcase
    endtask

    task automatic route_access(input logic act, input logic [15:0] addr,
                                input logic [7:0] data, output result_t res);
        logic in_ram_win;
        in_ram_win = (addr >= 16'hA000) && (addr < 16'hC000);
        res.target           = TGT_INTERNAL;
        res.physical_address = {6'd0, addr};
        res.write_strobe     = 1'b0;
        if (act == ACT_WRITE)
        begin
            if (!addr[15])
            begin
                apply_control_write(addr, data);
                res.target           = TGT_ABSORB;
                res.physical_address = '0;
            end
            else if (in_ram_win)
            begin
                if (ram_en)
                begin
                    res.target           = TGT_RAM;
                    res.physical_address = {7'd0, ram_bank, addr[12:0]};
                    res.write_strobe     = 1'b1;
                end
                else
                begin
                    res.target           = TGT_ABSORB;
                    res.physical_address = '0;
                end
            end
            else if (addr >= RO_AREA_LO && addr < RO_AREA_HI)
            begin
                res.target           = TGT_ABSORB;
                res.physical_address = '0;
            end
            else
                res.write_strobe = 1'b1;
        end
        else if (addr[15:14] == 2'b01)
        begin
            res.target           = TGT_ROM;
            res.physical_address = {rom_bank, addr[13:0]};
        end
        else if (in_ram_win)
        begin
            res.target           = TGT_RAM;
            res.physical_address = {7'd0, ram_bank, addr[12:0]};
        end
        res.rom_bank_now    = rom_bank;
        res.ram_bank_now    = ram_bank;
        res.ram_enabled_now = ram_en;
    endtask

    function automatic int field_diff(input string name, input logic [21:0] want,
                                      input logic [21:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            map_type = MAPPER_NONE;
            rom_bank = 8'd1;
            ram_bank = 2'd0;
            ram_en   = 1'b0;
            rom_mode = 1'b0;
            routing_q.delete();
            failures = 0;
            checked  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                map_type = cfg_data;
            // compare before pushing: a request taken at this edge cannot return yet
            if (out_valid && out_ready)
            begin
                if (routing_q.size() == 0)
                begin
                    $display("%0t: result with no request outstanding: target %0d addr 0x%0h",
                             $time, target, physical_address);
                    failures++;
                end
                else
                begin
                    want = routing_q.pop_front();
                    checked++;
                    failures += field_diff("target", 22'(want.target), 22'(target));
                    failures += field_diff("physical_address", want.physical_address,
                                           physical_address);
                    failures += field_diff("write_strobe", 22'(want.write_strobe),
                                           22'(write_strobe));
                    failures += field_diff("rom_bank_now", 22'(want.rom_bank_now),
                                           22'(rom_bank_now));
                    failures += field_diff("ram_bank_now", 22'(want.ram_bank_now),
                                           22'(ram_bank_now));
                    failures += field_diff("ram_enabled_now", 22'(want.ram_enabled_now),
                                           22'(ram_enabled_now));
                end
            end
            if (in_valid && in_ready)
            begin
                route_access(action, address, write_data, fresh);
                routing_q.push_back(fresh);
            end
        end
        pending = routing_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus top for the cartridge bank mapper: clock, reset, request and config
// drivers, result back-pressure and the final verdict.
// Depends on cbm_pkg, cbm_tb_pkg, cbm_checker and cartridge_bank_mapper_top.
module tb_top;
    import cbm_pkg::*;
    import cbm_tb_pkg::*;

    localparam int HALF_PERIOD     = 4;
    // slowest run is about 1200 requests plus drains;
    // the limit leaves a wide margin over that
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_BLOCK = 96;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [1:0]  cfg_data   = MAPPER_NONE;
    logic        in_valid   = 1'b0;
    logic        action     = ACT_READ;
    logic [15:0] address    = '0;
    logic [7:0]  write_data = '0;
    logic        out_ready  = 1'b0;

    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  target;
    logic [21:0] physical_address;
    logic        write_strobe;
    logic [7:0]  rom_bank_now;
    logic [1:0]  ram_bank_now;
    logic        ram_enabled_now;

    int failures;
    int pending;
    int checked;
    int cycles          = 0;
    int sent            = 0;
    int directed_sent   = 0;
    int settings_used   = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    // mapper types for the random blocks, one per block, rotated per idle phase
    logic [1:0] type_order [3] = '{MAPPER_TYPE1, MAPPER_TYPE2, MAPPER_NONE};
    int         idle_mix   [4] = '{0, 77, 0, 20};
    int         stall_mix  [4] = '{0, 0, 77, 20};

    cartridge_bank_mapper_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .address          (address),
        .write_data       (write_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .target           (target),
        .physical_address (physical_address),
        .write_strobe     (write_strobe),
        .rom_bank_now     (rom_bank_now),
        .ram_bank_now     (ram_bank_now),
        .ram_enabled_now  (ram_enabled_now)
    );

    cbm_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .address          (address),
        .write_data       (write_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .target           (target),
        .physical_address (physical_address),
        .write_strobe     (write_strobe),
        .rom_bank_now     (rom_bank_now),
        .ram_bank_now     (ram_bank_now),
        .ram_enabled_now  (ram_enabled_now),
        .failures         (failures),
        .pending          (pending),
        .checked          (checked)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Result side back-pressure: a fresh coin every cycle, so stalls land on
    // every phase of the two-stage pipe, including the one-deep input skid.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: a hung handshake or a drain that never empties ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // One request. Valid is only lowered when the sender decides to idle, so a
    // back-to-back request never sees valid dropped and raised in one step.
    task automatic send_access(input logic act, input logic [15:0] addr,
                               input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        address    <= addr;
        write_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // Stop sending and let every outstanding request come back, then wait on
    // for the two register stages to settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mapper type changes only with the pipe empty.
    task automatic set_mapper_type(input logic [1:0] mtype);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= mtype;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random access, weighted toward the regions where the state matters:
    // control writes (with RAM enable/disable codes favored), the RAM window,
    // ROM bank reads and the edges of the read-only area; the rest is noise.
    task automatic random_access();
        logic        act;
        logic [15:0] addr;
        logic [7:0]  data;
        int unsigned pick;
        pick = $urandom_range(99);
        act  = 1'($urandom_range(1));
        addr = 16'($urandom);
        data = 8'($urandom);
        if (pick < 30)
        begin
            act      = ACT_WRITE;
            addr[15] = 1'b0;
            if (addr[14:13] == WIN_RAM_EN && $urandom_range(3) != 0)
                data[3:0] = $urandom_range(1) ? RAM_EN_CODE : RAM_DIS_CODE;
        end
        else if (pick < 52)
            addr = 16'hA000 + 16'($urandom_range(16'h1FFF));
        else if (pick < 72)
        begin
            act  = ACT_READ;
            addr = 16'h4000 + 16'($urandom_range(16'h3FFF));
        end
        else if (pick < 80)
            addr = 16'hFE98 + 16'($urandom_range(16'h6F));
        send_access(act, addr, data);
    endtask

    initial
    begin
        // Reset held from the start, then released once.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, light idling on both sides.
        send_idle_pct  = 20;
        recv_stall_pct = 20;

        // Reset state, no mapper: routing basics and absorbed control writes.
        send_access(ACT_READ,  16'h0000, 8'hFF);  // low read served internally, data ignored
        send_access(ACT_READ,  16'h4000, 8'h00);  // ROM bank 1 after reset
        send_access(ACT_READ,  16'hA000, 8'h00);  // RAM read while disabled still goes to RAM
        send_access(ACT_WRITE, 16'h0000, 8'h0A);  // no mapper: enable code absorbed
        send_access(ACT_WRITE, 16'hA000, 8'h00);  // disabled RAM write dropped
        send_access(ACT_WRITE, 16'hFEA0, 8'h11);  // read-only area, low edge
        send_access(ACT_WRITE, 16'hFEFF, 8'hFF);  // just past read-only area
        send_access(ACT_WRITE, 16'hFFFF, 8'h80);  // top of bus, internal write

        // First mapper type: enable, bank writes, zero-bank fix, mode switch.
        set_mapper_type(MAPPER_TYPE1);
        send_access(ACT_WRITE, 16'h1FFF, 8'h0A);  // RAM enable
        send_access(ACT_WRITE, 16'hBFFF, 8'h5A);  // RAM write goes through
        send_access(ACT_WRITE, 16'h2000, 8'h00);  // bank 0 turns into 1
        send_access(ACT_WRITE, 16'h3FFF, 8'hFF);  // low five bits only
        send_access(ACT_WRITE, 16'h4000, 8'h03);  // RAM bank 3 in RAM banking mode
        send_access(ACT_READ,  16'hBFFF, 8'h00);  // top of RAM bank 3
        send_access(ACT_WRITE, 16'h6000, 8'h00);  // ROM banking mode, clears RAM bank
        send_access(ACT_WRITE, 16'h5FFF, 8'hE0);  // high ROM bank bits -> bank 0xFF
        send_access(ACT_READ,  16'h7FFF, 8'h00);  // largest physical ROM address
        send_access(ACT_WRITE, 16'h0000, 8'h05);  // neither code: enable unchanged
        send_access(ACT_WRITE, 16'h0000, 8'h10);  // low nibble zero disables
        send_access(ACT_WRITE, 16'h7FFF, 8'h01);  // back to RAM banking mode

        // Second mapper type: address bit 4 gate and the 4-bit bank.
        set_mapper_type(MAPPER_TYPE2);
        send_access(ACT_WRITE, 16'h0010, 8'h0A);  // bit 4 set: ignored
        send_access(ACT_WRITE, 16'h0000, 8'h0A);  // enable
        send_access(ACT_WRITE, 16'h2000, 8'hF0);  // masked to zero, becomes 1
        send_access(ACT_WRITE, 16'h2000, 8'h0F);  // bank 15
        send_access(ACT_WRITE, 16'h6000, 8'h00);  // mode window has no effect here
        send_access(ACT_READ,  16'h8000, 8'h00);  // internal read above ROM
        directed_sent = sent;

        // Random part: four idle/stall mixes, each visiting all three mapper
        // types in a rotated order so every transition between them occurs.
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int blk = 0; blk < 3; blk++)
            begin
                set_mapper_type(type_order[(phase + blk) % 3]);
                send_idle_pct  = idle_mix[phase];
                recv_stall_pct = stall_mix[phase];
                for (int n = 0; n < ITEMS_PER_BLOCK; n++)
                    random_access();
                // drain under the phase's stall rate, then relax
                wait_idle();
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
        end

        wait_idle();
        $display("Covered %0d bus accesses (%0d directed) over %0d mapper type settings",
                 sent, directed_sent, settings_used);
        $display("Checked %0d results across four idle/stall mixes, %0d mismatches",
                 checked, failures);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_in_stage.sv
rtl/cbm_bank_ctrl.sv
rtl/cbm_route.sv
rtl/cartridge_bank_mapper_top.sv
tb/cbm_tb_pkg.sv
tb/cbm_checker.sv
tb/tb_top.sv
